// ----- rtl/core/lslf_pkg.sv -----
// Package for the least-squares line fit: widths, operation and status codes,
// and the command/status structs shared by controller and datapath. No dependencies.
package lslf_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int IN_W       = 16;
   localparam int OUT_W      = 48;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = CNT_W + IN_W;
   localparam int SQ_W   = CNT_W + 2 * IN_W - 1;
   localparam int ACC_W  = SUM_W + SQ_W + 1;
   localparam int NUM_W  = ACC_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      OP_N_SXX,
      OP_SX_SX,
      OP_N_SXY,
      OP_SX_SY,
      OP_SXX_SY,
      OP_SX_SXY
   } mac_op_type;

   typedef enum logic [1:0] {
      FIT_OK    = 2'd0,
      FIT_DEGEN = 2'd1,
      FIT_SAT   = 2'd2,
      FIT_OVER  = 2'd3
   } fit_status_type;

   typedef struct packed {
      logic       accum;
      logic       mac_load;
      mac_op_type mac_op;
      logic       mac_step;
      logic       den_save;
      logic       div_load;
      logic       div_step;
      logic       res_save;
      logic       res_icpt;
      logic       out_load;
   } lslf_cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic acc_zero;
      logic div_busy;
      logic out_free;
   } lslf_stat_type;

endpackage

// ----- rtl/core/lslf_req_if.sv -----
// Point channel: valid/ready handshake with one (x, y, last) point per transfer.
// Depends on lslf_pkg.
interface lslf_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [lslf_pkg::IN_W-1:0] x_value;
   logic signed [lslf_pkg::IN_W-1:0] y_value;
   logic                             last_point;

   modport source (output valid, x_value, y_value, last_point, input ready);
   modport sink (input valid, x_value, y_value, last_point, output ready);
endinterface

// ----- rtl/core/lslf_rsp_if.sv -----
// Result channel: valid/ready handshake with one fit result per transfer.
// Depends on lslf_pkg.
interface lslf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lslf_pkg::OUT_W-1:0] slope;
   logic signed [lslf_pkg::OUT_W-1:0] intercept;
   logic [1:0]                        fit_status;

   modport source (output valid, slope, intercept, fit_status, input ready);
   modport sink (input valid, slope, intercept, fit_status, output ready);
endinterface

// ----- rtl/core/least_squares_line_fit.sv -----
// Least-squares line fit: points are taken one per cycle and summed; the transfer
// that carries the last-point flag closes the set, and the slope and intercept
// (Q32.16, rounded to nearest, saturated) are then worked out by a serial
// multiply-accumulate unit (six products, one multiplier bit per cycle) and a
// restoring divider (one quotient bit per cycle); this work, and any wait for the
// output register, takes place while no point is taken. A degenerate set skips
// the divisions. A finished result waits in the output register while the next
// set streams in.
// Depends on lslf_pkg, lslf_req_if, lslf_rsp_if, lslf_ctrl, lslf_datapath.
module least_squares_line_fit (
   input  logic       clock,
   input  logic       reset,
   lslf_req_if.sink   req_chan,
   lslf_rsp_if.source rsp_chan
);
   import lslf_pkg::*;

   lslf_cmd_type  cmd;
   lslf_stat_type stat;
   logic          ready;

   assign req_chan.ready = ready;

   lslf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_point),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lslf_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .x_in  (req_chan.x_value),
      .y_in  (req_chan.y_value),
      .rsp   (rsp_chan)
   );

endmodule

// ----- rtl/core/lslf_datapath.sv -----
// Datapath: point accumulators, serial multiply-accumulate, restoring divider,
// rounding/saturation and the result register. Depends on lslf_pkg, lslf_rsp_if.
module lslf_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lslf_pkg::lslf_cmd_type           cmd,
   output lslf_pkg::lslf_stat_type          stat,
   input  logic signed [lslf_pkg::IN_W-1:0] x_in,
   input  logic signed [lslf_pkg::IN_W-1:0] y_in,
   lslf_rsp_if.source                       rsp
);
   import lslf_pkg::*;

   localparam logic [NUM_W:0] POS_LIM = (NUM_W + 1)'({1'b0, {(OUT_W - 1){1'b1}}});
   localparam logic [NUM_W:0] NEG_LIM = POS_LIM + (NUM_W + 1)'(1);

   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0] sx_ff, sy_ff;
   logic signed [SQ_W-1:0]  sxy_ff, sxx_ff;
   logic                    ovf_ff;

   logic signed [2*IN_W-1:0] xy_prod, xx_prod;
   logic signed [SUM_W-1:0]  n_s;

   logic signed [ACC_W-1:0] acc_ff, ma_ff;
   logic [SUM_W-1:0]        mb_ff;
   logic                    mneg_ff;
   logic signed [ACC_W-1:0] mac_a;
   logic signed [SUM_W-1:0] mac_b;
   logic                    mac_sub;

   logic [ACC_W-1:0]  den_ff;
   logic [ACC_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  numsh_ff, q_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              dneg_ff;
   logic [ACC_W-1:0]  acc_mag;
   logic [ACC_W:0]    trial, diff;
   logic              ge;

   logic              rnd, sat_now, sat_ff;
   logic [NUM_W:0]    qr;
   logic [OUT_W-1:0]  res_val, slope_ff, icpt_ff;

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_slope_ff, rsp_icpt_ff;
   logic [1:0]        rsp_status_ff;

   assign xy_prod = x_in * y_in;
   assign xx_prod = x_in * x_in;
   assign n_s     = SUM_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accum) begin
         if (cnt_ff < CNT_W'(MAX_POINTS)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            sx_ff  <= sx_ff + SUM_W'(x_in);
            sy_ff  <= sy_ff + SUM_W'(y_in);
            sxy_ff <= sxy_ff + SQ_W'(xy_prod);
            sxx_ff <= sxx_ff + SQ_W'(xx_prod);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      mac_a   = '0;
      mac_b   = '0;
      mac_sub = 1'b0;
      case (cmd.mac_op)
         OP_N_SXX: begin
            mac_a = ACC_W'(sxx_ff);
            mac_b = n_s;
         end
         OP_SX_SX: begin
            mac_a   = ACC_W'(sx_ff);
            mac_b   = sx_ff;
            mac_sub = 1'b1;
         end
         OP_N_SXY: begin
            mac_a = ACC_W'(sxy_ff);
            mac_b = n_s;
         end
         OP_SX_SY: begin
            mac_a   = ACC_W'(sy_ff);
            mac_b   = sx_ff;
            mac_sub = 1'b1;
         end
         OP_SXX_SY: begin
            mac_a = ACC_W'(sxx_ff);
            mac_b = sy_ff;
         end
         OP_SX_SXY: begin
            mac_a   = ACC_W'(sxy_ff);
            mac_b   = sx_ff;
            mac_sub = 1'b1;
         end
         default: begin
            mac_a   = '0;
            mac_b   = '0;
            mac_sub = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_ff <= '0;
      end else if (cmd.mac_load) begin
         if (!mac_sub) begin
            acc_ff <= '0;
         end
         ma_ff   <= mac_a;
         mb_ff   <= mac_b[SUM_W-1] ? SUM_W'(-mac_b) : SUM_W'(mac_b);
         mneg_ff <= mac_b[SUM_W-1] ^ mac_sub;
      end else if (cmd.mac_step) begin
         if (mb_ff[0]) begin
            acc_ff <= mneg_ff ? acc_ff - ma_ff : acc_ff + ma_ff;
         end
         ma_ff <= ma_ff <<< 1;
         mb_ff <= mb_ff >> 1;
      end
   end

   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign trial   = {rem_ff, numsh_ff[NUM_W-1]};
   assign diff    = trial - {1'b0, den_ff};
   assign ge      = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_load) begin
         dneg_ff  <= acc_ff[ACC_W-1];
         numsh_ff <= NUM_W'(acc_mag) << FRAC_BITS;
         rem_ff   <= '0;
         q_ff     <= '0;
         dcnt_ff  <= DCNT_W'(NUM_W);
      end else if (cmd.div_step) begin
         rem_ff   <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
         q_ff     <= {q_ff[NUM_W-2:0], ge};
         numsh_ff <= numsh_ff << 1;
         dcnt_ff  <= dcnt_ff - DCNT_W'(1);
      end
      if (cmd.den_save) begin
         den_ff <= acc_ff;
      end
   end

   assign rnd     = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign qr      = {1'b0, q_ff} + (NUM_W + 1)'(rnd);
   assign sat_now = qr > (dneg_ff ? NEG_LIM : POS_LIM);

   always_comb begin
      if (sat_now) begin
         res_val = dneg_ff ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
      end else begin
         res_val = dneg_ff ? OUT_W'(-qr[OUT_W-1:0]) : qr[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         sat_ff <= 1'b0;
      end else if (cmd.res_save) begin
         sat_ff <= sat_ff | sat_now;
      end
      if (cmd.res_save) begin
         if (cmd.res_icpt) begin
            icpt_ff <= res_val;
         end else begin
            slope_ff <= res_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff  <= 1'b1;
         rsp_slope_ff  <= (den_ff == '0) ? '0 : slope_ff;
         rsp_icpt_ff   <= (den_ff == '0) ? '0 : icpt_ff;
         if (ovf_ff) begin
            rsp_status_ff <= FIT_OVER;
         end else if (den_ff == '0) begin
            rsp_status_ff <= FIT_DEGEN;
         end else if (sat_ff) begin
            rsp_status_ff <= FIT_SAT;
         end else begin
            rsp_status_ff <= FIT_OK;
         end
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.slope      = rsp_slope_ff;
   assign rsp.intercept  = rsp_icpt_ff;
   assign rsp.fit_status = rsp_status_ff;

   assign stat.mac_busy = mb_ff != '0;
   assign stat.acc_zero = acc_ff == '0;
   assign stat.div_busy = dcnt_ff != '0;
   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count past limit");

   a_div_den: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> den_ff != '0)
      else $error("division started with zero denominator");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < den_ff)
      else $error("remainder not below denominator");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && den_ff == '0 |=> rsp_slope_ff == '0 && rsp_icpt_ff == '0)
      else $error("degenerate fit with nonzero output");

endmodule

// ----- rtl/core/lslf_ctrl.sv -----
// Controller: sequences accumulation, the six serial products, the two divisions
// and the result load. Depends on lslf_pkg.
module lslf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   input  lslf_pkg::lslf_stat_type stat,
   output lslf_pkg::lslf_cmd_type  cmd
);
   import lslf_pkg::*;

   typedef enum logic [2:0] {
      S_POINTS,
      S_MLOAD,
      S_MRUN,
      S_DRUN,
      S_FINISH
   } state_type;

   state_type  state_ff;
   mac_op_type op_ff;

   assign req_ready = state_ff == S_POINTS;

   always_comb begin
      cmd        = '0;
      cmd.mac_op = op_ff;
      case (state_ff)
         S_POINTS: cmd.accum = req_valid;
         S_MLOAD:  cmd.mac_load = 1'b1;
         S_MRUN: begin
            if (stat.mac_busy) begin
               cmd.mac_step = 1'b1;
            end else if (op_ff == OP_SX_SX) begin
               cmd.den_save = 1'b1;
            end else if (op_ff == OP_SX_SY || op_ff == OP_SX_SXY) begin
               cmd.div_load = 1'b1;
            end
         end
         S_DRUN: begin
            cmd.res_icpt = op_ff == OP_SX_SXY;
            if (stat.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.res_save = 1'b1;
            end
         end
         S_FINISH: cmd.out_load = stat.out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_POINTS;
         op_ff    <= OP_N_SXX;
      end else begin
         case (state_ff)
            S_POINTS: begin
               if (req_valid && req_last) begin
                  op_ff    <= OP_N_SXX;
                  state_ff <= S_MLOAD;
               end
            end
            S_MLOAD: state_ff <= S_MRUN;
            S_MRUN: begin
               if (!stat.mac_busy) begin
                  case (op_ff)
                     OP_N_SXX: begin
                        op_ff    <= OP_SX_SX;
                        state_ff <= S_MLOAD;
                     end
                     OP_SX_SX: begin
                        if (stat.acc_zero) begin
                           state_ff <= S_FINISH;
                        end else begin
                           op_ff    <= OP_N_SXY;
                           state_ff <= S_MLOAD;
                        end
                     end
                     OP_N_SXY: begin
                        op_ff    <= OP_SX_SY;
                        state_ff <= S_MLOAD;
                     end
                     OP_SXX_SY: begin
                        op_ff    <= OP_SX_SXY;
                        state_ff <= S_MLOAD;
                     end
                     default: state_ff <= S_DRUN;
                  endcase
               end
            end
            S_DRUN: begin
               if (!stat.div_busy) begin
                  if (op_ff == OP_SX_SY) begin
                     op_ff    <= OP_SXX_SY;
                     state_ff <= S_MLOAD;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= S_POINTS;
               end
            end
            default: state_ff <= S_POINTS;
         endcase
      end
   end

endmodule
